>>> hdl/bsd_pkg.sv
// Shared constants and types for the 2x2 box-sum downsampler.
package bsd_pkg;

  // Image limits and pixel format
  localparam int unsigned MaxWidth  = 1024;
  localparam int unsigned MaxHeight = 1024;
  localparam int unsigned PixelBits = 16;

  // Derived widths
  localparam int unsigned DimW      = 11;                       // size register width
  localparam int unsigned ColW      = $clog2(MaxWidth);         // column counter
  localparam int unsigned RowW      = $clog2(MaxHeight);        // row counter
  localparam int unsigned LineDepth = (MaxWidth + 1) / 2;       // pair sums per line
  localparam int unsigned LineAw    = $clog2(LineDepth);
  localparam int unsigned PairW     = PixelBits + 1;
  localparam int unsigned SumW      = 18;
  localparam int unsigned CoordW    = 9;

  // Stream payloads
  localparam int unsigned InDataW   = 16;
  localparam int unsigned OutFieldW = SumW + 2 * CoordW;
  localparam int unsigned OutDataW  = ((OutFieldW + 7) / 8) * 8;

  // Configuration port
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] RegImageWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegImageHeight = 2'd1;
  localparam logic [DimW-1:0] ResetWidth  = 11'd640;
  localparam logic [DimW-1:0] ResetHeight = 11'd480;

  // One accepted pixel that completes a 2x2 block
  typedef struct packed {
    logic [PairW-1:0]  pair;      // horizontal pair sum of this row
    logic              use_line;  // add the stored pair sum of the row above
    logic [CoordW-1:0] out_x;
    logic [CoordW-1:0] out_y;
    logic              last;      // final result of the frame
  } bsd_item_t;

endpackage

>>> hdl/box_sum_downsample_2x2.sv
// Top level of the 2x2 box-sum downsampler. Takes a raster frame of
// unsigned 16-bit pixels and emits one exact sum per 2x2 block (pixels
// outside the image count as zero), tagged with its half-size column and
// row; tlast marks the final result of the frame. Throughput is one pixel
// per cycle unless stalled: each pixel costs at most one line-store read
// or write, and results pass the line-store read, then the result
// register. The line store is not cleared after reset; a frame starts on
// row zero. The user must write width and height (1..1024) only while the
// block is idle; the block itself does not enforce this.
module box_sum_downsample_2x2 (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Pixel stream; tdata: pixel_value[15:0]
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [bsd_pkg::InDataW-1:0]   s_axis_tdata,
  // Result stream; tdata: box_sum[17:0], out_x[26:18], out_y[35:27], zero
  // fill[39:36]; tlast: frame_last
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [bsd_pkg::OutDataW-1:0]  m_axis_tdata,
  output logic                          m_axis_tlast,
  // Register writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bsd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [bsd_pkg::DimW-1:0]      cfg_data_i
);

  logic [bsd_pkg::DimW-1:0]   width_q, height_q;
  logic                       dn_ready;
  logic                       item_valid;
  bsd_pkg::bsd_item_t         item;
  logic                       line_we, line_re;
  logic [bsd_pkg::LineAw-1:0] line_addr;
  logic [bsd_pkg::PairW-1:0]  line_wdata, line_rdata;

  // Size registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= bsd_pkg::ResetWidth;
      height_q <= bsd_pkg::ResetHeight;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        bsd_pkg::RegImageWidth:  width_q  <= cfg_data_i;
        bsd_pkg::RegImageHeight: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  bsd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_pixel_i   (s_axis_tdata),
    .dn_ready_i   (dn_ready),
    .in_ready_o   (s_axis_tready),
    .width_i      (width_q),
    .height_i     (height_q),
    .item_valid_o (item_valid),
    .item_o       (item),
    .line_we_o    (line_we),
    .line_re_o    (line_re),
    .line_addr_o  (line_addr),
    .line_wdata_o (line_wdata)
  );

  // Pair sums of the even row
  bsd_ram #(
    .Width (bsd_pkg::PairW),
    .Depth (bsd_pkg::LineDepth)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (line_we),
    .waddr_i (line_addr),
    .wdata_i (line_wdata),
    .re_i    (line_re),
    .raddr_i (line_addr),
    .rdata_o (line_rdata)
  );

  bsd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .ready_o      (dn_ready),
    .line_rdata_i (line_rdata),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (m_axis_tdata),
    .out_last_o   (m_axis_tlast)
  );

endmodule

>>> hdl/bsd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bsd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/bsd_front.sv
// Raster position tracking, horizontal pairing and line store access.
module bsd_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic [bsd_pkg::InDataW-1:0] in_pixel_i,
  input  logic                        dn_ready_i,
  output logic                        in_ready_o,
  input  logic [bsd_pkg::DimW-1:0]    width_i,
  input  logic [bsd_pkg::DimW-1:0]    height_i,
  output logic                        item_valid_o,
  output bsd_pkg::bsd_item_t          item_o,
  output logic                        line_we_o,
  output logic                        line_re_o,
  output logic [bsd_pkg::LineAw-1:0]  line_addr_o,
  output logic [bsd_pkg::PairW-1:0]   line_wdata_o
);

  logic [bsd_pkg::ColW-1:0]      col_q, col_d;
  logic [bsd_pkg::RowW-1:0]      row_q, row_d;
  logic [bsd_pkg::PixelBits-1:0] left_q, left_d;

  logic                          accept;
  logic [bsd_pkg::ColW-1:0]      col_max;
  logic [bsd_pkg::RowW-1:0]      row_max;
  logic                          last_col, last_row, odd_col, odd_row;
  logic                          pair_done, block_done;
  logic [bsd_pkg::PixelBits-1:0] pix;
  logic [bsd_pkg::PairW-1:0]     pair;

  assign accept     = in_valid_i & dn_ready_i;
  assign in_ready_o = dn_ready_i;
  assign pix        = in_pixel_i[bsd_pkg::PixelBits-1:0];

  // Last column / row index: zero size acts as one, oversize clamps
  always_comb begin
    if (width_i == '0) begin
      col_max = '0;
    end else if (width_i > bsd_pkg::DimW'(bsd_pkg::MaxWidth)) begin
      col_max = bsd_pkg::ColW'(bsd_pkg::MaxWidth - 1);
    end else begin
      col_max = bsd_pkg::ColW'(width_i - 1'b1);
    end
    if (height_i == '0) begin
      row_max = '0;
    end else if (height_i > bsd_pkg::DimW'(bsd_pkg::MaxHeight)) begin
      row_max = bsd_pkg::RowW'(bsd_pkg::MaxHeight - 1);
    end else begin
      row_max = bsd_pkg::RowW'(height_i - 1'b1);
    end
  end

  // Position flags; a count past the end after a size change is the end
  assign last_col   = (col_q >= col_max);
  assign last_row   = (row_q >= row_max);
  assign odd_col    = col_q[0];
  assign odd_row    = row_q[0];
  assign pair_done  = odd_col | last_col;
  assign block_done = pair_done & (odd_row | last_row);

  // Horizontal pair; a missing right partner counts as zero
  assign pair = odd_col ? ({1'b0, left_q} + {1'b0, pix}) : {1'b0, pix};

  // Line store: park even-row pair sums, fetch them on the odd row
  assign line_addr_o  = col_q[bsd_pkg::ColW-1:1];
  assign line_wdata_o = pair;
  assign line_we_o    = accept & pair_done & ~(odd_row | last_row);
  assign line_re_o    = accept & block_done & odd_row;

  // Item handed to the sum stage
  assign item_valid_o   = accept & block_done;
  assign item_o.pair     = pair;
  assign item_o.use_line = odd_row;
  assign item_o.out_x    = bsd_pkg::CoordW'(col_q >> 1);
  assign item_o.out_y    = bsd_pkg::CoordW'(row_q >> 1);
  assign item_o.last     = last_col & last_row;

  // Counter and left pixel update
  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    left_d = left_q;
    if (accept) begin
      if (!pair_done) begin
        left_d = pix;
      end
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      left_q <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      left_q <= left_d;
    end
  end

endmodule

>>> hdl/bsd_back.sv
// Sum stage and output register of the downsampler.
module bsd_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              item_valid_i,
  input  bsd_pkg::bsd_item_t                item_i,
  output logic                              ready_o,
  input  logic [bsd_pkg::PairW-1:0]         line_rdata_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [bsd_pkg::OutDataW-1:0]      out_data_o,
  output logic                              out_last_o
);

  localparam int unsigned PadW = bsd_pkg::OutDataW - bsd_pkg::OutFieldW;

  logic                        s1_valid_q;
  bsd_pkg::bsd_item_t          s1_q;
  logic                        out_valid_q;
  logic [bsd_pkg::SumW-1:0]    sum_q, sum_d;
  logic [bsd_pkg::CoordW-1:0]  x_q, y_q;
  logic                        last_q;
  logic                        out_adv;

  // Pipeline moves when the result register is free or being taken
  assign out_adv = ~out_valid_q | out_ready_i;
  assign ready_o = ~s1_valid_q | out_adv;

  // Vertical sum with the pair parked from the row above
  always_comb begin
    sum_d = bsd_pkg::SumW'(s1_q.pair);
    if (s1_q.use_line) begin
      sum_d = bsd_pkg::SumW'(s1_q.pair) + bsd_pkg::SumW'(line_rdata_i);
    end
  end

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ready_o) begin
        s1_valid_q <= item_valid_i;
      end
      if (out_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (ready_o && item_valid_i) begin
      s1_q <= item_i;
    end
    if (out_adv && s1_valid_q) begin
      sum_q  <= sum_d;
      x_q    <= s1_q.out_x;
      y_q    <= s1_q.out_y;
      last_q <= s1_q.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {{PadW{1'b0}}, y_q, x_q, sum_q};
  assign out_last_o  = last_q;

endmodule

>>> hdl/bsd_checker.sv
// Port-level checks for the downsampler, bound to the top level.
module bsd_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [bsd_pkg::OutDataW-1:0] m_axis_tdata,
  input logic                         m_axis_tlast
);

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // Sum never exceeds four full-scale pixels
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[bsd_pkg::SumW-1:0] <= bsd_pkg::SumW'(262140))
    else $error("box sum out of range");

  // Fill bits above the fields stay zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[bsd_pkg::OutDataW-1:bsd_pkg::OutFieldW] == '0)
    else $error("result fill bits set");

  // No result right after reset
  assert property (@(posedge clk_i) $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("result valid out of reset");

endmodule

bind box_sum_downsample_2x2 bsd_checker u_bsd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

>>> verif/testbench.sv
// Self-checking testbench for the 2x2 box-sum downsampler: directed table, then random frames.
module testbench;
  import bsd_pkg::*;

  localparam int unsigned DrainCycles = 8;     // result pipe is two deep, line write one
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned RandomItems = 1000;
  localparam int unsigned NumRows     = 32;

  // Indexes past the register list; writes to them must be ignored
  localparam logic [CfgIdxW-1:0] RegSpareA = 2'd2;
  localparam logic [CfgIdxW-1:0] RegSpareB = 2'd3;

  typedef struct packed {
    logic [SumW-1:0]   box_sum;
    logic [CoordW-1:0] out_x;
    logic [CoordW-1:0] out_y;
    logic              frame_last;
  } box_result_t;

  typedef enum logic {RowReg, RowPixel} row_kind_e;
  typedef enum logic [1:0] {CheckModel, CheckNone, CheckGiven} row_check_e;

  typedef struct packed {
    row_kind_e          kind;
    logic [CfgIdxW-1:0] index;
    logic [15:0]        value;   // pixel, or register data in the low DimW bits
    row_check_e         check;
    box_result_t        want;
  } dir_row_t;

  // Directed items; sizes after reset are 640 x 480
  dir_row_t dir_rows [NumRows] = '{
    '{RowReg,   RegImageHeight, 16'd1,     CheckNone,  '0},
    '{RowPixel, '0,             16'd1,     CheckNone,  '0},
    '{RowPixel, '0,             16'd2,     CheckGiven, '{18'd3, 9'd0, 9'd0, 1'b0}},
    // shrink width mid-row: column 2 is past the end, so it closes the frame
    '{RowReg,   RegImageWidth,  16'd2,     CheckNone,  '0},
    '{RowPixel, '0,             16'd5,     CheckGiven, '{18'd5, 9'd1, 9'd0, 1'b1}},
    '{RowReg,   RegImageHeight, 16'd2,     CheckNone,  '0},
    // full-scale block
    '{RowPixel, '0,             16'hFFFF,  CheckNone,  '0},
    '{RowPixel, '0,             16'hFFFF,  CheckNone,  '0},
    '{RowPixel, '0,             16'hFFFF,  CheckNone,  '0},
    '{RowPixel, '0,             16'hFFFF,  CheckGiven, '{18'd262140, 9'd0, 9'd0, 1'b1}},
    '{RowPixel, '0,             16'd0,     CheckNone,  '0},
    '{RowPixel, '0,             16'd0,     CheckNone,  '0},
    '{RowPixel, '0,             16'd0,     CheckNone,  '0},
    '{RowPixel, '0,             16'd0,     CheckGiven, '{18'd0, 9'd0, 9'd0, 1'b1}},
    // odd width and height: right column and bottom row pad with zero
    '{RowReg,   RegImageWidth,  16'd3,     CheckNone,  '0},
    '{RowReg,   RegImageHeight, 16'd3,     CheckNone,  '0},
    '{RowPixel, '0,             16'd1,     CheckNone,  '0},
    '{RowPixel, '0,             16'd2,     CheckNone,  '0},
    '{RowPixel, '0,             16'd4,     CheckNone,  '0},
    '{RowPixel, '0,             16'd8,     CheckNone,  '0},
    '{RowPixel, '0,             16'd16,    CheckGiven, '{18'd27, 9'd0, 9'd0, 1'b0}},
    '{RowPixel, '0,             16'd32,    CheckGiven, '{18'd36, 9'd1, 9'd0, 1'b0}},
    '{RowPixel, '0,             16'd64,    CheckNone,  '0},
    '{RowPixel, '0,             16'd128,   CheckGiven, '{18'd192, 9'd0, 9'd1, 1'b0}},
    '{RowPixel, '0,             16'd256,   CheckGiven, '{18'd256, 9'd1, 9'd1, 1'b1}},
    // zero sizes act as one
    '{RowReg,   RegImageWidth,  16'd0,     CheckNone,  '0},
    '{RowReg,   RegImageHeight, 16'd0,     CheckNone,  '0},
    '{RowPixel, '0,             16'd7,     CheckGiven, '{18'd7, 9'd0, 9'd0, 1'b1}},
    '{RowReg,   RegSpareA,      16'd5,     CheckNone,  '0},
    '{RowReg,   RegSpareB,      16'd2047,  CheckNone,  '0},
    '{RowPixel, '0,             16'd9,     CheckGiven, '{18'd9, 9'd0, 9'd0, 1'b1}},
    '{RowPixel, '0,             16'hBEEF,  CheckModel, '0}
  };

  logic                 clk_i;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InDataW-1:0]   s_axis_tdata  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutDataW-1:0]  m_axis_tdata;
  logic                 m_axis_tlast;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i   = '0;
  logic [DimW-1:0]      cfg_data_i    = '0;

  // Predictor state
  logic [DimW-1:0]      width_reg;
  logic [DimW-1:0]      height_reg;
  int unsigned          col_pos;
  int unsigned          row_pos;
  logic [PixelBits-1:0] left_hold;
  logic [PairW-1:0]     pair_line [LineDepth];

  box_result_t          sums_due [$];
  int unsigned          mismatches;
  int unsigned          results_seen;
  int unsigned          stall_cycles;
  int unsigned          tx_idle_pct;
  int unsigned          rx_idle_pct;

  box_sum_downsample_2x2 DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned eff_size(input logic [DimW-1:0] v, input int unsigned limit);
    if (v == 0) return 1;
    if (v > limit) return limit;
    return 32'(v);
  endfunction

  // Advance the downsampler state by one pixel; returns 1 when a 2x2 block completes
  function automatic bit predict_box_sum(input logic [PixelBits-1:0] pix,
                                         output box_result_t res);
    int unsigned      w;
    int unsigned      h;
    int unsigned      idx;
    bit               last_col;
    bit               last_row;
    bit               odd_col;
    bit               odd_row;
    bit               done;
    logic [PairW-1:0] pair;
    w        = eff_size(width_reg, MaxWidth);
    h        = eff_size(height_reg, MaxHeight);
    last_col = (col_pos + 1 >= w);
    last_row = (row_pos + 1 >= h);
    odd_col  = col_pos[0];
    odd_row  = row_pos[0];
    idx      = col_pos >> 1;
    if (idx >= LineDepth) idx = LineDepth - 1;
    done = 1'b0;
    res  = '0;
    if (odd_col || last_col) begin
      pair = PairW'(pix);
      if (odd_col) pair = pair + PairW'(left_hold);
      if (odd_row || last_row) begin
        res.box_sum = SumW'(pair);
        if (odd_row) res.box_sum = res.box_sum + SumW'(pair_line[idx]);
        res.out_x      = CoordW'(col_pos >> 1);
        res.out_y      = CoordW'(row_pos >> 1);
        res.frame_last = last_col && last_row;
        done = 1'b1;
      end else begin
        pair_line[idx] = pair;
      end
    end else begin
      left_hold = pix;
    end
    // raster counters; a count past the new end is treated as the end
    if (last_col) begin
      col_pos = 0;
      row_pos = last_row ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
    return done;
  endfunction

  function automatic logic [PixelBits-1:0] rand_pixel();
    int unsigned pick;
    pick = $urandom_range(9, 0);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return PixelBits'($urandom);
  endfunction

  function automatic logic [DimW-1:0] rand_size(input int unsigned top);
    if ($urandom_range(11, 0) == 0) return '0;
    return DimW'($urandom_range(top, 1));
  endfunction

  task automatic report_mismatch(input string what);
    $display("ERROR: result %0d: %s", results_seen, what);
    mismatches++;
  endtask

  task automatic check_field(input string name, input int unsigned got, input int unsigned want);
    if (got != want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  task automatic wait_drained();
    while (sums_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Register write, only once the block has gone quiet
  task automatic write_reg(input logic [CfgIdxW-1:0] index, input logic [DimW-1:0] data);
    s_axis_tvalid <= 1'b0;
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (index == RegImageWidth) width_reg = data;
    else if (index == RegImageHeight) height_reg = data;
  endtask

  // One pixel item, with random gaps ahead of it
  task automatic push_pixel(input logic [PixelBits-1:0] pix, input row_check_e check,
                            input box_result_t want);
    box_result_t res;
    bit          hit;
    while ($urandom_range(99, 0) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pix;
    do @(posedge clk_i); while (!s_axis_tready);
    hit = predict_box_sum(pix, res);
    if (check == CheckGiven) sums_due.push_back(want);
    else if (check == CheckModel && hit) sums_due.push_back(res);
  endtask

  task automatic send_pixels(input int unsigned count);
    repeat (count) push_pixel(rand_pixel(), CheckModel, '0);
  endtask

  // Receiver stalls
  always @(posedge clk_i) m_axis_tready <= ($urandom_range(99, 0) >= rx_idle_pct);

  // Result checker
  always @(posedge clk_i) begin
    box_result_t got;
    box_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.box_sum    = m_axis_tdata[SumW-1:0];
      got.out_x      = m_axis_tdata[SumW+CoordW-1:SumW];
      got.out_y      = m_axis_tdata[SumW+2*CoordW-1:SumW+CoordW];
      got.frame_last = m_axis_tlast;
      if (sums_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result sum %0d x %0d y %0d last %0d",
                                  got.box_sum, got.out_x, got.out_y, got.frame_last));
      end else begin
        want = sums_due.pop_front();
        check_field("box_sum", 32'(got.box_sum), 32'(want.box_sum));
        check_field("out_x", 32'(got.out_x), 32'(want.out_x));
        check_field("out_y", 32'(got.out_y), 32'(want.out_y));
        check_field("frame_last", 32'(got.frame_last), 32'(want.frame_last));
      end
      results_seen++;
    end
  end

  // Watchdog on cycles without any accepted item
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("ERROR: nothing accepted for %0d cycles", StallLimit);
      $display("Mismatches found");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Stimulus
  initial begin
    int unsigned fed;
    int unsigned mode;
    int unsigned w;
    int unsigned h;
    int unsigned n;
    int unsigned rows_pre;
    width_reg    = ResetWidth;
    height_reg   = ResetHeight;
    col_pos      = 0;
    row_pos      = 0;
    left_hold    = '0;
    foreach (pair_line[i]) pair_line[i] = '0;
    tx_idle_pct  = 11;
    rx_idle_pct  = 58;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == RowReg) write_reg(dir_rows[i].index, DimW'(dir_rows[i].value));
      else push_pixel(dir_rows[i].value, dir_rows[i].check, dir_rows[i].want);
    end

    fed = 0;
    while (fed < RandomItems) begin
      // thirds: slow receiver, then slow sender, then no gaps
      mode        = fed * 3 / RandomItems;
      tx_idle_pct = (mode == 0) ? 11 : (mode == 1) ? 58 : 0;
      rx_idle_pct = (mode == 0) ? 58 : (mode == 1) ? 11 : 0;
      if ($urandom_range(3, 0) != 0) begin
        // whole frames at a small size
        if ($urandom_range(2, 0) != 0) write_reg(RegImageWidth, rand_size(12));
        if ($urandom_range(2, 0) != 0) write_reg(RegImageHeight, rand_size(8));
        if ($urandom_range(7, 0) == 0)
          write_reg($urandom_range(1, 0) ? RegSpareA : RegSpareB, DimW'($urandom));
        n = eff_size(width_reg, MaxWidth) * eff_size(height_reg, MaxHeight) *
            $urandom_range(3, 1);
        send_pixels(n);
        fed += n;
      end else begin
        // resize partway into an even row, then finish the frame at the new size
        write_reg(RegImageWidth,
                  ($urandom_range(9, 0) == 0) ? DimW'(2047) : rand_size(12));
        write_reg(RegImageHeight,
                  ($urandom_range(9, 0) == 0) ? DimW'(2047) : rand_size(8));
        w = eff_size(width_reg, MaxWidth);
        h = eff_size(height_reg, MaxHeight);
        rows_pre = 0;
        if (w <= 16 && h > 2)
          rows_pre = 2 * $urandom_range(((h - 1) / 2 < 3) ? (h - 1) / 2 : 3, 0);
        n = rows_pre * w + $urandom_range(((w < 16) ? w : 16) - 1, 0);
        send_pixels(n);
        if (w > 12 || $urandom_range(1, 0) != 0) write_reg(RegImageWidth, rand_size(12));
        if (h > 8 || $urandom_range(1, 0) != 0) write_reg(RegImageHeight, rand_size(8));
        while (col_pos != 0 || row_pos != 0) begin
          push_pixel(rand_pixel(), CheckModel, '0);
          n++;
        end
        fed += n;
      end
    end

    s_axis_tvalid <= 1'b0;
    wait_drained();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
